[rtl/vbs_pkg.sv]
package vbs_pkg;

    localparam int FRAME_WIDTH_DEF  = 320;
    localparam int FRAME_HEIGHT_DEF = 240;
    localparam int SAMPLES_DEF      = 20;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 9;
    localparam int GRAY_W  = 8;
    localparam int SLOT_W  = 5;
    localparam int RAND_W  = 16;
    localparam int RAD_W   = 8;
    localparam int MINM_W  = 5;
    localparam int FACT_W  = 8;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCHES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMPLE    = 2'd2;

    localparam logic MODE_INIT   = 1'b0;
    localparam logic MODE_DETECT = 1'b1;

    localparam logic [RAD_W-1:0]  RADIUS_RST = 8'd20;
    localparam logic [MINM_W-1:0] MINM_RST   = 5'd2;
    localparam logic [FACT_W-1:0] FACT_RST   = 8'd16;

    typedef struct packed {
        logic                mode;
        logic [ROW_W-1:0]    pixel_row;
        logic [COL_W-1:0]    pixel_col;
        logic [GRAY_W-1:0]   gray_value;
        logic [SLOT_W-1:0]   init_slot;
        logic [RAND_W-1:0]   rand_slot;
        logic [RAND_W-1:0]   rand_update;
        logic [RAND_W-1:0]   rand_row_offset;
        logic [RAND_W-1:0]   rand_col_offset;
        logic [RAND_W-1:0]   rand_neighbor_slot;
    } t_in_item;

    typedef struct packed {
        logic             foreground;
        logic [CNT_W-1:0] match_count;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic mod_start;
        logic rd_issue;
        logic rd_capture;
        logic wr_init;
        logic wr_own;
        logic wr_nbr;
        logic out_load;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic in_frame;
        logic mode;
        logic init_ok;
        logic mod_done;
        logic fg;
        logic draw_one;
        logic draw_two;
        logic nbr_ok;
    } t_status;

endpackage

[rtl/vbs_stream_if.sv]
interface vbs_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/vbs_ctrl.sv]
module vbs_ctrl #(
    parameter int SAMPLES = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  vbs_pkg::t_status  i_status,
    output vbs_pkg::t_cmd     o_cmd
);
    import vbs_pkg::*;

    localparam int RC_W = $clog2(SAMPLES + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [RC_W-1:0] r_cnt, n_cnt;
    logic            r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_cnt = '0;
                if (!i_status.in_frame) begin
                    n_state = S_IDLE;
                end else if (i_status.mode == MODE_INIT) begin
                    o_cmd.wr_init = i_status.init_ok;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                if (r_cnt < RC_W'(SAMPLES)) begin
                    o_cmd.rd_issue = 1'b1;
                end
                if (r_cnt != '0) begin
                    o_cmd.rd_capture = 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == RC_W'(SAMPLES)) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (i_status.mod_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (!i_status.fg) begin
                    o_cmd.wr_own = i_status.draw_one;
                    o_cmd.wr_nbr = i_status.draw_two && i_status.nbr_ok;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end
endmodule

[rtl/vbs_datapath.sv]
module vbs_datapath #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240,
    parameter int SAMPLES      = 20
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  vbs_pkg::t_in_item         i_item,
    input  logic [vbs_pkg::RAD_W-1:0]  i_radius,
    input  logic [vbs_pkg::MINM_W-1:0] i_min_matches,
    input  logic [vbs_pkg::FACT_W-1:0] i_factor,
    input  vbs_pkg::t_cmd             i_cmd,
    output vbs_pkg::t_status          o_status,
    output vbs_pkg::t_out_item        o_result
);
    import vbs_pkg::*;

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT * SAMPLES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PIX_W  = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
    localparam int SL_W   = $clog2(SAMPLES);
    localparam int HIT_W  = $clog2(SAMPLES + 1);
    localparam int REC_SH = RAND_W + 6;
    localparam longint REC_S = ((longint'(1) <<< REC_SH) + SAMPLES - 1) / SAMPLES;
    localparam longint REC_3 = ((longint'(1) <<< REC_SH) + 2) / 3;

    logic [GRAY_W-1:0] r_mem [DEPTH];

    t_in_item          r_item;
    logic [ADDR_W-1:0] r_base;
    logic [SL_W-1:0]   r_rd_slot;
    logic [GRAY_W-1:0] r_rd_data;
    logic [HIT_W-1:0]  r_hits;
    logic [ADDR_W-1:0] r_nbr_base;
    logic              r_nbr_ok;
    logic [SL_W-1:0]   r_own_slot, r_nbr_slot;
    logic [1:0]        r_roff, r_coff;
    logic [RAND_W-1:0] r_rem;
    logic [4:0]        r_mstep;
    logic              r_mbusy;
    t_out_item         r_res;

    logic [ROW_W+1:0]  w_nr;
    logic [COL_W+1:0]  w_nc;
    logic [GRAY_W:0]   w_diff;
    logic [GRAY_W-1:0] w_abs;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_we;

    // Remainder by a small constant through a reciprocal multiply.
    function automatic logic [RAND_W-1:0] f_mod_recip(
        input logic [RAND_W-1:0] a, input logic [REC_SH-1:0] rec, input logic [6:0] d
    );
        logic [RAND_W+REC_SH-1:0] prod;
        logic [RAND_W-1:0]        q;
        prod = {{REC_SH{1'b0}}, a} * {{RAND_W{1'b0}}, rec};
        q    = prod[RAND_W+REC_SH-1:REC_SH];
        return a - RAND_W'(q * {{(RAND_W-7){1'b0}}, d});
    endfunction

    assign w_nr = {2'b0, r_item.pixel_row} + {2'b0, r_roff};
    assign w_nc = {2'b0, r_item.pixel_col} + {2'b0, r_coff};

    always_comb begin
        w_diff = {1'b0, r_rd_data} - {1'b0, r_item.gray_value};
        w_abs  = w_diff[GRAY_W] ? GRAY_W'(-w_diff) : w_diff[GRAY_W-1:0];
    end

    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_base + ADDR_W'(r_item.init_slot);
        if (i_cmd.wr_own) begin
            w_waddr = r_base + ADDR_W'(r_own_slot);
        end else if (i_cmd.wr_nbr) begin
            w_waddr = r_nbr_base + ADDR_W'(r_nbr_slot);
        end else if (!i_cmd.wr_init) begin
            w_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= r_item.gray_value;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_base + ADDR_W'(r_rd_slot)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item     <= i_item;
            r_base     <= ADDR_W'((PIX_W'(i_item.pixel_row) * PIX_W'(FRAME_WIDTH)
                          + PIX_W'(i_item.pixel_col)) * ADDR_W'(SAMPLES));
            r_own_slot <= SL_W'(f_mod_recip(i_item.rand_slot, REC_SH'(REC_S), 7'(SAMPLES)));
            r_nbr_slot <= SL_W'(f_mod_recip(i_item.rand_neighbor_slot, REC_SH'(REC_S),
                                            7'(SAMPLES)));
            r_roff     <= 2'(f_mod_recip(i_item.rand_row_offset, REC_SH'(REC_3), 7'd3));
            r_coff     <= 2'(f_mod_recip(i_item.rand_col_offset, REC_SH'(REC_3), 7'd3));
            r_rd_slot  <= '0;
            r_hits     <= '0;
        end
        if (i_cmd.mod_start) begin
            r_nbr_ok   <= (w_nr >= 1) && (w_nc >= 1)
                          && (w_nr - 1 < FRAME_HEIGHT) && (w_nc - 1 < FRAME_WIDTH);
            r_nbr_base <= ADDR_W'((PIX_W'(w_nr - 1'b1) * PIX_W'(FRAME_WIDTH)
                          + PIX_W'(w_nc - 1'b1)) * ADDR_W'(SAMPLES));
        end
        if (i_cmd.rd_issue) begin
            r_rd_slot <= r_rd_slot + 1'b1;
        end
        if (i_cmd.rd_capture && ({1'b0, w_abs} < {1'b0, i_radius})) begin
            r_hits <= r_hits + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_res.foreground  <= o_status.fg;
            r_res.match_count <= (r_hits > HIT_W'(31)) ? CNT_W'(31) : CNT_W'(r_hits);
        end
    end

    // Restoring remainder of rand_update by (factor + 1), one bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mstep <= '0;
        end else if (i_cmd.mod_start) begin
            r_mbusy <= 1'b1;
            r_mstep <= 5'd15;
            r_rem   <= '0;
        end else if (r_mbusy) begin
            begin
                logic [RAND_W:0] t;
                t = {r_rem, r_item.rand_update[r_mstep[3:0]]};
                if (t >= (RAND_W+1)'({1'b0, i_factor} + 1'b1)) begin
                    t = t - (RAND_W+1)'({1'b0, i_factor} + 1'b1);
                end
                r_rem <= RAND_W'(t);
            end
            if (r_mstep == 5'd0) begin
                r_mbusy <= 1'b0;
            end
            r_mstep <= r_mstep - 1'b1;
        end
    end

    assign o_status.in_frame = 32'(r_item.pixel_row) < FRAME_HEIGHT
                               && 32'(r_item.pixel_col) < FRAME_WIDTH;
    assign o_status.mode     = r_item.mode;
    assign o_status.init_ok  = 32'(r_item.init_slot) < SAMPLES;
    assign o_status.mod_done = !r_mbusy;
    assign o_status.fg       = {{(32-HIT_W){1'b0}}, r_hits} < 32'(i_min_matches);
    assign o_status.draw_one = (r_rem == RAND_W'(1));
    assign o_status.draw_two = (r_rem == RAND_W'(2));
    assign o_status.nbr_ok   = r_nbr_ok;
    assign o_result          = r_res;
endmodule

[rtl/vibe_background_subtractor_core.sv]
// ViBe background subtractor: the time a detect item takes is set by one
// sample-memory read a cycle and a 16-step bit-serial remainder for the update
// draw, plus any wait for the previous result to be taken; an init item or an
// item outside the frame goes back to idle straight from the decode state.
// Only detect items inside the frame produce a result. The sample memory needs
// no clearing after reset.
module vibe_background_subtractor_core
    import vbs_pkg::*;
#(
    parameter int FRAME_WIDTH       = vbs_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT      = vbs_pkg::FRAME_HEIGHT_DEF,
    parameter int SAMPLES_PER_PIXEL = vbs_pkg::SAMPLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vbs_pkg::CFG_DAT_W-1:0] i_cfg_data,
    vbs_stream_if.sink                    in_if,
    vbs_stream_if.source                  out_if
);

    logic [RAD_W-1:0]  r_radius;
    logic [MINM_W-1:0] r_min_matches;
    logic [FACT_W-1:0] r_factor;
    t_cmd              w_cmd;
    t_status           w_status;
    t_out_item         w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= RADIUS_RST;
            r_min_matches <= MINM_RST;
            r_factor      <= FACT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MATCH_RADIUS: r_radius      <= i_cfg_data[RAD_W-1:0];
                CFG_MIN_MATCHES:  r_min_matches <= i_cfg_data[MINM_W-1:0];
                CFG_SUBSAMPLE:    r_factor      <= i_cfg_data[FACT_W-1:0];
                default: ;
            endcase
        end
    end

    vbs_ctrl #(.SAMPLES(SAMPLES_PER_PIXEL)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_if.valid),
        .o_in_ready (in_if.ready),
        .o_out_valid(out_if.valid),
        .i_out_ready(out_if.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    vbs_datapath #(
        .FRAME_WIDTH (FRAME_WIDTH),
        .FRAME_HEIGHT(FRAME_HEIGHT),
        .SAMPLES     (SAMPLES_PER_PIXEL)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (in_if.data),
        .i_radius     (r_radius),
        .i_min_matches(r_min_matches),
        .i_factor     (r_factor),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_result     (w_res)
    );

    assign out_if.data = w_res;

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.wr_init, w_cmd.wr_own, w_cmd.wr_nbr}) <= 1)
        else $error("more than one sample write in a cycle");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_issue |-> !in_if.ready)
        else $error("item accepted during sample reads");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_if.valid && !out_if.ready) |=> out_if.valid && $stable(out_if.data))
        else $error("result changed while stalled");

endmodule
